// ----- rtl/iorr_pkg.sv -----
// ----------------------------------------------------------------------------
// iorr_pkg
// Shared types and defaults for the in-order reply reorder core.
// ----------------------------------------------------------------------------
package iorr_pkg;

    localparam int WINDOW_DEF      = 16;
    localparam int HANDLE_BITS_DEF = 16;
    localparam int ID_BITS         = 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN
    } t_state;

    typedef enum logic [2:0] {
        PUSH_NONE,
        PUSH_DIRECT,
        PUSH_ERROR,
        PUSH_PEND_MID,
        PUSH_PEND_LAST
    } t_push;

    typedef struct packed {
        logic  cap_in;
        logic  store_slot;
        logic  advance;
        logic  clear_head;
        logic  pend_load_in;
        logic  pend_load_slot;
        logic  pend_clear;
        t_push push;
    } t_cmd;

    typedef struct packed {
        logic pass_through;
        logic out_of_window;
        logic dist_zero;
        logic in_present;
        logic head_valid;
        logic head_has_buf;
        logic pend_valid;
        logic out_free;
    } t_status;

endpackage

// ----- rtl/iorr_ctrl.sv -----
// ----------------------------------------------------------------------------
// iorr_ctrl
// Sequencer: takes a transaction, classifies it, then walks held slots.
// ----------------------------------------------------------------------------
module iorr_ctrl
    import iorr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output logic    o_stall,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_status.pass_through) begin
                    if (!i_status.in_present || i_status.out_free) begin
                        n_state = S_IDLE;
                    end
                end else if (i_status.out_of_window) begin
                    if (i_status.out_free) begin
                        n_state = S_IDLE;
                    end
                end else if (i_status.dist_zero) begin
                    n_state = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!i_status.head_valid) begin
                    if (!i_status.pend_valid || i_status.out_free) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '{default: '0, push: PUSH_NONE};
        o_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.cap_in = i_valid;
            end
            S_EVAL: begin
                if (i_status.pass_through) begin
                    if (i_status.in_present && i_status.out_free) begin
                        o_cmd.push = PUSH_DIRECT;
                    end
                end else if (i_status.out_of_window) begin
                    if (i_status.out_free) begin
                        o_cmd.push = PUSH_ERROR;
                    end
                end else if (i_status.dist_zero) begin
                    o_cmd.pend_load_in = 1'b1;
                    o_cmd.advance      = 1'b1;
                end else begin
                    o_cmd.store_slot = 1'b1;
                end
            end
            S_SCAN: begin
                if (i_status.head_valid) begin
                    // a buffered slot displaces the pending result
                    if (!(i_status.head_has_buf && i_status.pend_valid &&
                          !i_status.out_free)) begin
                        o_cmd.clear_head = 1'b1;
                        o_cmd.advance    = 1'b1;
                        if (i_status.head_has_buf) begin
                            o_cmd.pend_load_slot = 1'b1;
                            if (i_status.pend_valid) begin
                                o_cmd.push = PUSH_PEND_MID;
                            end
                        end
                    end
                end else if (i_status.pend_valid) begin
                    if (i_status.out_free) begin
                        o_cmd.push       = PUSH_PEND_LAST;
                        o_cmd.pend_clear = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- rtl/iorr_dp.sv -----
// ----------------------------------------------------------------------------
// iorr_dp
// Datapath: input capture, head pointer, slot table, pending and output regs.
// ----------------------------------------------------------------------------
module iorr_dp
    import iorr_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_pass_through,
    input  logic [ID_BITS-1:0]     i_reply_id,
    input  logic [HANDLE_BITS-1:0] i_reply_handle,
    input  logic                   i_buffer_present,
    input  logic                   i_stall,
    input  t_cmd                   i_cmd,
    output t_status                o_status,
    output logic                   o_valid,
    output logic [HANDLE_BITS-1:0] o_out_handle,
    output logic [ID_BITS-1:0]     o_out_id,
    output logic                   o_window_error,
    output logic                   o_last_of_run
);

    localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [SW-1:0]      LAST_SLOT = SW'(WINDOW - 1);
    localparam logic [ID_BITS-1:0] WIN_ID    = ID_BITS'(WINDOW);

    logic                   r_pass_through;
    logic [ID_BITS-1:0]     r_in_id;
    logic [HANDLE_BITS-1:0] r_in_handle;
    logic                   r_in_present;
    logic [ID_BITS-1:0]     r_head_id;
    logic [SW-1:0]          r_head_slot;
    logic [WINDOW-1:0]      r_slot_valid;
    logic [WINDOW-1:0]      r_slot_buf;
    logic [HANDLE_BITS-1:0] r_slot_handle [WINDOW];
    logic                   r_pend_valid;
    logic [HANDLE_BITS-1:0] r_pend_handle;
    logic [ID_BITS-1:0]     r_pend_id;
    logic                   r_out_valid;
    logic [HANDLE_BITS-1:0] r_out_handle;
    logic [ID_BITS-1:0]     r_out_id;
    logic                   r_out_err;
    logic                   r_out_last;

    logic [ID_BITS-1:0] id_offset;
    logic [SW:0]        slot_sum;
    logic [SW-1:0]      store_slot;
    logic               out_free;

    assign id_offset = r_in_id - r_head_id;
    assign slot_sum  = {1'b0, r_head_slot} + {1'b0, id_offset[SW-1:0]};
    assign store_slot = (slot_sum >= (SW+1)'(WINDOW)) ?
                        SW'(slot_sum - (SW+1)'(WINDOW)) : slot_sum[SW-1:0];
    assign out_free = !r_out_valid || !i_stall;

    assign o_status.pass_through  = r_pass_through;
    assign o_status.out_of_window = (id_offset >= WIN_ID);
    assign o_status.dist_zero     = (id_offset == '0);
    assign o_status.in_present    = r_in_present;
    assign o_status.head_valid    = r_slot_valid[r_head_slot];
    assign o_status.head_has_buf  = r_slot_buf[r_head_slot];
    assign o_status.pend_valid    = r_pend_valid;
    assign o_status.out_free      = out_free;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_through <= 1'b0;
            r_head_id      <= '0;
            r_head_slot    <= '0;
            r_slot_valid   <= '0;
            r_pend_valid   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_pass_through <= i_cfg_pass_through;
            end
            if (i_cmd.advance) begin
                r_head_id   <= r_head_id + 1'b1;
                r_head_slot <= (r_head_slot == LAST_SLOT) ? '0 : r_head_slot + 1'b1;
            end
            if (i_cmd.clear_head) begin
                r_slot_valid[r_head_slot] <= 1'b0;
            end
            // duplicate early ids keep the first reply
            if (i_cmd.store_slot && !r_slot_valid[store_slot]) begin
                r_slot_valid[store_slot] <= 1'b1;
            end
            if (i_cmd.pend_load_in) begin
                r_pend_valid <= r_in_present;
            end else if (i_cmd.pend_load_slot) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.pend_clear) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.push != PUSH_NONE) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_in_id      <= i_reply_id;
            r_in_handle  <= i_reply_handle;
            r_in_present <= i_buffer_present;
        end
        if (i_cmd.store_slot && !r_slot_valid[store_slot]) begin
            r_slot_buf[store_slot]    <= r_in_present;
            r_slot_handle[store_slot] <= r_in_handle;
        end
        if (i_cmd.pend_load_in) begin
            r_pend_handle <= r_in_handle;
            r_pend_id     <= r_in_id;
        end else if (i_cmd.pend_load_slot) begin
            r_pend_handle <= r_slot_handle[r_head_slot];
            r_pend_id     <= r_head_id;
        end
        case (i_cmd.push)
            PUSH_DIRECT: begin
                r_out_handle <= r_in_handle;
                r_out_id     <= r_in_id;
                r_out_err    <= 1'b0;
                r_out_last   <= 1'b1;
            end
            PUSH_ERROR: begin
                r_out_handle <= '0;
                r_out_id     <= r_in_id;
                r_out_err    <= 1'b1;
                r_out_last   <= 1'b1;
            end
            PUSH_PEND_MID: begin
                r_out_handle <= r_pend_handle;
                r_out_id     <= r_pend_id;
                r_out_err    <= 1'b0;
                r_out_last   <= 1'b0;
            end
            PUSH_PEND_LAST: begin
                r_out_handle <= r_pend_handle;
                r_out_id     <= r_pend_id;
                r_out_err    <= 1'b0;
                r_out_last   <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_valid        = r_out_valid;
    assign o_out_handle   = r_out_handle;
    assign o_out_id       = r_out_id;
    assign o_window_error = r_out_err;
    assign o_last_of_run  = r_out_last;

endmodule

// ----- rtl/in_order_reply_reorder_core.sv -----
// ----------------------------------------------------------------------------
// in_order_reply_reorder_core
// Releases completed replies in request order, or in arrival order when
// pass-through is set.
// ----------------------------------------------------------------------------
// The core takes one reply transaction at a time. A reply is captured, then
// classified; a reply at the head id then has the sequencer walk each held
// slot of the run in turn and close the run (held replies without a buffer
// are walked but release nothing). The sequencer walks the slot table one
// entry per cycle, but a buffered slot waits while a result is pending and
// the output is stalled. Results are delayed by one step so that last_of_run
// can be marked on the final released reply. Early replies wait in a
// WINDOW-entry slot table; ids outside the window come out once with
// window_error set and are dropped.
module in_order_reply_reorder_core
    import iorr_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_pass_through,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [ID_BITS-1:0]     i_reply_id,
    input  logic [HANDLE_BITS-1:0] i_reply_handle,
    input  logic                   i_buffer_present,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [HANDLE_BITS-1:0] o_out_handle,
    output logic [ID_BITS-1:0]     o_out_id,
    output logic                   o_window_error,
    output logic                   o_last_of_run
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    iorr_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_stall  (o_stall),
        .o_cmd    (cmd)
    );

    iorr_dp #(
        .WINDOW      (WINDOW),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_pass_through (i_cfg_pass_through),
        .i_reply_id         (i_reply_id),
        .i_reply_handle     (i_reply_handle),
        .i_buffer_present   (i_buffer_present),
        .i_stall            (i_stall),
        .i_cmd              (cmd),
        .o_status           (status),
        .o_valid            (o_valid),
        .o_out_handle       (o_out_handle),
        .o_out_id           (o_out_id),
        .o_window_error     (o_window_error),
        .o_last_of_run      (o_last_of_run)
    );

endmodule

// ----- test/iorr_release_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iorr_release_checker
// Watches the config, reply and release channels of the reorder core, keeps
// its own copy of the head id and slot table, and compares every released
// transaction against the oldest predicted one.
// ----------------------------------------------------------------------------
module iorr_release_checker
    import iorr_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic                   i_cfg_pass_through,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [ID_BITS-1:0]     i_reply_id,
    input  logic [HANDLE_BITS-1:0] i_reply_handle,
    input  logic                   i_buffer_present,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [HANDLE_BITS-1:0] i_out_handle,
    input  logic [ID_BITS-1:0]     i_out_id,
    input  logic                   i_window_error,
    input  logic                   i_last_of_run,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_window_errs
);

    typedef struct packed {
        logic [HANDLE_BITS-1:0] handle;
        logic [ID_BITS-1:0]     id;
        logic                   err;
        logic                   last;
    } t_release;

    t_release               release_q[$];
    logic                   pass_mode;
    logic [ID_BITS-1:0]     head_id;
    int unsigned            head_slot;
    logic                   held[WINDOW];
    logic                   held_buf[WINDOW];
    logic [HANDLE_BITS-1:0] held_handle[WINDOW];

    always @(posedge i_clk) begin : watch
        t_release           run_q[$];
        t_release           want;
        t_release           got;
        logic [ID_BITS-1:0] id_offset;
        int unsigned        s;

        if (!i_rst_n) begin
            release_q.delete();
            pass_mode = 1'b0;
            head_id   = '0;
            head_slot = 0;
            for (int i = 0; i < WINDOW; i++) begin
                held[i]        = 1'b0;
                held_buf[i]    = 1'b0;
                held_handle[i] = '0;
            end
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                pass_mode = i_cfg_pass_through;

            if (i_out_valid && !i_out_stall) begin
                got = '{handle: i_out_handle, id: i_out_id, err: i_window_error,
                        last: i_last_of_run};
                o_checked++;
                if (got.err)
                    o_window_errs++;
                if (release_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: unexpected release handle=%h id=%h err=%b last=%b",
                                 $realtime, got.handle, got.id, got.err, got.last);
                    o_fail_count++;
                end else begin
                    want = release_q.pop_front();
                    if (got.handle !== want.handle || got.id !== want.id ||
                        got.err !== want.err || got.last !== want.last) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: release mismatch exp handle=%h id=%h err=%b last=%b",
                                     $realtime, want.handle, want.id, want.err, want.last);
                            $display("    got handle=%h id=%h err=%b last=%b",
                                     got.handle, got.id, got.err, got.last);
                        end
                        o_fail_count++;
                    end
                end
            end

            // reply transaction: work out what it releases
            if (i_in_valid && !i_in_stall) begin
                run_q.delete();
                id_offset = i_reply_id - head_id;
                if (pass_mode) begin
                    if (i_buffer_present)
                        run_q.push_back('{handle: i_reply_handle, id: i_reply_id,
                                          err: 1'b0, last: 1'b0});
                end else if (id_offset >= WINDOW) begin
                    // stale or too far ahead: flagged, state untouched
                    run_q.push_back('{handle: '0, id: i_reply_id, err: 1'b1, last: 1'b0});
                end else if (id_offset == 0) begin
                    if (i_buffer_present)
                        run_q.push_back('{handle: i_reply_handle, id: i_reply_id,
                                          err: 1'b0, last: 1'b0});
                    head_id++;
                    head_slot = (head_slot + 1) % WINDOW;
                    while (held[head_slot] && run_q.size() < WINDOW) begin
                        held[head_slot] = 1'b0;
                        // held reply without a buffer is skipped silently
                        if (held_buf[head_slot])
                            run_q.push_back('{handle: held_handle[head_slot], id: head_id,
                                              err: 1'b0, last: 1'b0});
                        head_id++;
                        head_slot = (head_slot + 1) % WINDOW;
                    end
                end else begin
                    s = (head_slot + id_offset) % WINDOW;
                    // duplicate early id keeps the first copy
                    if (!held[s]) begin
                        held[s]        = 1'b1;
                        held_buf[s]    = i_buffer_present;
                        held_handle[s] = i_reply_handle;
                    end
                end
                if (run_q.size() > 0)
                    run_q[run_q.size()-1].last = 1'b1;
                foreach (run_q[i])
                    release_q.push_back(run_q[i]);
            end
        end
        o_pending = release_q.size();
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives reply transactions into the reorder core in both release modes,
// with bursty input, a randomly stalling output and one long output hold-off;
// the checker predicts and compares every release.
// ----------------------------------------------------------------------------
module testbench
    import iorr_pkg::*;
();

    localparam int WINDOW       = WINDOW_DEF;
    localparam int HANDLE_BITS  = HANDLE_BITS_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 40;
    localparam int HOLD_CYCLES  = 300;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic                   i_cfg_pass_through;
    logic                   i_valid;
    logic                   o_stall;
    logic [ID_BITS-1:0]     i_reply_id;
    logic [HANDLE_BITS-1:0] i_reply_handle;
    logic                   i_buffer_present;
    logic                   o_valid;
    logic                   i_stall;
    logic [HANDLE_BITS-1:0] o_out_handle;
    logic [ID_BITS-1:0]     o_out_id;
    logic                   o_window_error;
    logic                   o_last_of_run;

    int                     fail_count;
    int                     pending;
    int                     checked;
    int                     window_errs;

    int                     replies_sent;
    int                     burst_left;
    logic [ID_BITS-1:0]     next_id;
    logic                   hold_req;
    int                     cycles;

    in_order_reply_reorder_core #(
        .WINDOW      (WINDOW),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_pass_through (i_cfg_pass_through),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_reply_id         (i_reply_id),
        .i_reply_handle     (i_reply_handle),
        .i_buffer_present   (i_buffer_present),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_out_handle       (o_out_handle),
        .o_out_id           (o_out_id),
        .o_window_error     (o_window_error),
        .o_last_of_run      (o_last_of_run)
    );

    iorr_release_checker #(
        .WINDOW      (WINDOW),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_check (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_pass_through (i_cfg_pass_through),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_reply_id         (i_reply_id),
        .i_reply_handle     (i_reply_handle),
        .i_buffer_present   (i_buffer_present),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_out_handle       (o_out_handle),
        .i_out_id           (o_out_id),
        .i_window_error     (o_window_error),
        .i_last_of_run      (o_last_of_run),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_checked          (checked),
        .o_window_errs      (window_errs)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles, %0d releases outstanding", cycles, pending);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Output side: stall pattern is redrawn from four random modes; one long
    // hold-off on request so the core backs up into its input.
    initial begin
        int mode;
        int mode_left;
        int hold_cnt;
        i_stall   = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold_cnt  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && hold_cnt < HOLD_CYCLES) begin
                hold_cnt++;
                i_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ~i_stall;
                endcase
            end
        end
    end

    task automatic write_pass_through(input logic value);
        i_cfg_valid        <= 1'b1;
        i_cfg_pass_through <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One reply transaction; bursts of random length with random gaps.
    task automatic offer_reply(input logic [ID_BITS-1:0] id,
                               input logic [HANDLE_BITS-1:0] handle,
                               input logic present);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid          <= 1'b1;
        i_reply_id       <= id;
        i_reply_handle   <= handle;
        i_buffer_present <= present;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        replies_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        // no-result replies may still be walking the slot table
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic run_pass_through(input int count);
        for (int n = 0; n < count; n++)
            offer_reply(ID_BITS'($urandom), HANDLE_BITS'($urandom),
                        ($urandom_range(0, 3) != 0));
    endtask

    // Complete id blocks, mostly in shuffled order, with out-of-window noise
    // and repeats of ids from the current block mixed in.
    task automatic run_reorder_blocks(input int min_count);
        int sent;
        int k;
        int sel;
        int j;
        int r;
        int tmp;
        int perm[16];
        sent = 0;
        while (sent < min_count) begin
            sel = $urandom_range(0, 9);
            if (sel < 7)
                k = $urandom_range(1, 4);
            else if (sel < 9)
                k = $urandom_range(5, 10);
            else
                k = $urandom_range(11, WINDOW);
            for (j = 0; j < k; j++)
                perm[j] = j;
            if ($urandom_range(0, 9) >= 3) begin
                for (j = k - 1; j > 0; j--) begin
                    r       = $urandom_range(0, j);
                    tmp     = perm[j];
                    perm[j] = perm[r];
                    perm[r] = tmp;
                end
            end
            for (j = 0; j < k; j++) begin
                if ($urandom_range(0, 9) == 0) begin
                    // offset 32..255 is outside the window wherever the head is
                    offer_reply(next_id + ID_BITS'($urandom_range(32, 255)),
                                HANDLE_BITS'($urandom), 1'($urandom_range(0, 1)));
                    sent++;
                end
                if (j > 0 && $urandom_range(0, 14) == 0) begin
                    offer_reply(next_id + ID_BITS'(perm[$urandom_range(0, j - 1)]),
                                HANDLE_BITS'($urandom), 1'($urandom_range(0, 1)));
                    sent++;
                end
                offer_reply(next_id + ID_BITS'(perm[j]), HANDLE_BITS'($urandom),
                            ($urandom_range(0, 6) != 0));
                sent++;
            end
            next_id = next_id + ID_BITS'(k);
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_valid        = 1'b0;
        i_cfg_pass_through = 1'b0;
        i_valid            = 1'b0;
        i_reply_id         = '0;
        i_reply_handle     = '0;
        i_buffer_present   = 1'b0;
        hold_req           = 1'b0;
        replies_sent       = 0;
        burst_left         = 0;
        next_id            = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reorder mode, head starts at 0
        write_pass_through(1'b0);
        offer_reply(8'd0, 16'hFFFF, 1'b1);
        offer_reply(8'd3, 16'h0000, 1'b1);
        offer_reply(8'd2, 16'h1234, 1'b0);
        offer_reply(8'd2, 16'h5678, 1'b1);      // duplicate of a held id
        offer_reply(8'd1, 16'hAAAA, 1'b1);      // releases 1, skips 2, releases 3
        offer_reply(8'd0, 16'h1111, 1'b1);      // already passed
        offer_reply(8'd20, 16'h2222, 1'b1);     // exactly one past the window
        offer_reply(8'd19, HANDLE_BITS'($urandom), 1'b1);  // last slot in the window
        for (int i = 5; i <= 18; i++)
            offer_reply(ID_BITS'(i), HANDLE_BITS'($urandom), 1'b1);
        offer_reply(8'd4, 16'h8001, 1'b1);      // full window run of releases
        offer_reply(8'd255, 16'hFFFF, 1'b1);
        offer_reply(8'd20, 16'h3333, 1'b0);     // head with no buffer
        next_id = 8'd21;
        wait_drained();

        write_pass_through(1'b1);
        offer_reply(8'd255, 16'hFFFF, 1'b1);
        offer_reply(8'd0, 16'h0000, 1'b0);
        offer_reply(8'd128, 16'h5555, 1'b1);
        run_pass_through(100);
        wait_drained();

        write_pass_through(1'b0);
        hold_req = 1'b1;
        run_reorder_blocks(150);
        wait_drained();

        write_pass_through(1'b1);
        run_pass_through(60);
        wait_drained();

        write_pass_through(1'b0);
        run_reorder_blocks(75);
        wait_drained();

        @(negedge i_clk);
        $display("Sent %0d replies over reorder and pass-through phases", replies_sent);
        $display("Compared %0d releases, %0d of them window errors", checked, window_errs);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
